// ===== hdl/mvt_pkg.sv =====
// ============================================================================
// Matrix vector transform package
// Shared constants, register codes and control types for the 4x4 matrix by
// vector transform unit.
// ============================================================================
package mvt_pkg;

   // Field widths of the vector and coefficient formats.
   localparam int VECTOR_WIDTH = 24;
   localparam int COEF_WIDTH   = 16;
   localparam int COEF_FRAC    = 12;

   // Matrix shape and the packing of one column register.
   localparam int NUM_ROWS     = 4;
   localparam int NUM_COLS     = 4;
   localparam int LANE_STRIDE  = 16;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;

   // Result queue depth; a power of two so the pointers wrap on their own.
   localparam int RSP_FIFO_DEPTH = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATRIX_COL0 = 2'd0,
      CSR_MATRIX_COL1 = 2'd1,
      CSR_MATRIX_COL2 = 2'd2,
      CSR_MATRIX_COL3 = 2'd3
   } csr_index_type;

   // Column registers after reset, column 3 first.
   localparam logic [NUM_COLS-1:0][CSR_DATA_W-1:0] MATRIX_RESET = {
      64'h1000_0000_0000_0000,
      64'h0000_1000_0000_0000,
      64'h0000_0000_1000_0000,
      64'h0001_0000_0000_1000
   };

   // Control that travels beside the data through the lane pipeline.
   typedef struct packed {
      logic valid;
      logic mode;
   } ctrl_type;

endpackage

// ===== hdl/mvt_lane.sv =====
// ============================================================================
// Matrix vector transform row lane
// Forms one row dot product: four products, their sum, then a floor shift
// and saturation to the vector width. Three register stages.
// ============================================================================
module mvt_lane #(
   parameter int VECTOR_WIDTH = mvt_pkg::VECTOR_WIDTH,
   parameter int COEF_WIDTH   = mvt_pkg::COEF_WIDTH
) (
   input  logic                                                   clock,
   input  logic [mvt_pkg::NUM_COLS-1:0][COEF_WIDTH-1:0]           coef_row,
   input  logic [mvt_pkg::NUM_COLS-1:0][VECTOR_WIDTH-1:0]         vec,
   output logic [VECTOR_WIDTH-1:0]                                res,
   output logic                                                   clip
);

   localparam int PROD_W = VECTOR_WIDTH + COEF_WIDTH;
   localparam int SUM_W  = PROD_W + 2;

   logic signed [PROD_W-1:0]    prod_in [mvt_pkg::NUM_COLS];
   logic signed [PROD_W-1:0]    prod_ff [mvt_pkg::NUM_COLS];
   logic signed [SUM_W-1:0]     sum_in;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [SUM_W-1:0]     shifted;
   logic                        overflow;
   logic [VECTOR_WIDTH-1:0]     res_in;
   logic [VECTOR_WIDTH-1:0]     res_ff;
   logic                        clip_ff;

   // Stage 1: one product per column.
   always_comb begin
      for (int c = 0; c < mvt_pkg::NUM_COLS; c++) begin
         prod_in[c] = $signed(coef_row[c]) * $signed(vec[c]);
      end
   end

   // Stage 2: exact sum of the four products.
   always_comb begin
      sum_in = '0;
      for (int c = 0; c < mvt_pkg::NUM_COLS; c++) begin
         sum_in = sum_in + SUM_W'(prod_ff[c]);
      end
   end

   // Stage 3: arithmetic shift floors toward minus infinity; the value fits
   // only when every bit from the result sign upward agrees.
   always_comb begin
      shifted  = sum_ff >>> mvt_pkg::COEF_FRAC;
      overflow = !((&shifted[SUM_W-1:VECTOR_WIDTH-1]) ||
                   !(|shifted[SUM_W-1:VECTOR_WIDTH-1]));
      if (!overflow) begin
         res_in = shifted[VECTOR_WIDTH-1:0];
      end else if (shifted[SUM_W-1]) begin
         res_in = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};
      end else begin
         res_in = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
      clip_ff <= overflow;
   end

   assign res  = res_ff;
   assign clip = clip_ff;

endmodule

// ===== hdl/mvt_merge.sv =====
// ============================================================================
// Matrix vector transform merge stage
// Combines the four lane results into one result item, applies the
// three-component masking, and queues the items for the result channel.
// ============================================================================
module mvt_merge #(
   parameter int VECTOR_WIDTH = mvt_pkg::VECTOR_WIDTH
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  mvt_pkg::ctrl_type                                    ctrl,
   input  logic [mvt_pkg::NUM_ROWS-1:0][VECTOR_WIDTH-1:0]       lane_res,
   input  logic [mvt_pkg::NUM_ROWS-1:0]                         lane_clip,
   input  logic                                                 rsp_pop,
   output logic                                                 rsp_valid,
   output logic [mvt_pkg::NUM_ROWS-1:0][VECTOR_WIDTH-1:0]       rsp_res,
   output logic                                                 rsp_sat
);

   localparam int DEPTH   = mvt_pkg::RSP_FIFO_DEPTH;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int LEVEL_W = $clog2(DEPTH + 1);
   localparam int ENTRY_W = mvt_pkg::NUM_ROWS * VECTOR_WIDTH + 1;

   logic [ENTRY_W-1:0]  entry_in;
   logic [ENTRY_W-1:0]  fifo_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [mvt_pkg::NUM_ROWS-1:0][VECTOR_WIDTH-1:0] merged;
   logic                merged_sat;
   logic                push;
   logic                pop;

   // In three-component mode the last row is forced to zero and its clip
   // flag does not count.
   always_comb begin
      merged     = lane_res;
      merged_sat = |lane_clip[mvt_pkg::NUM_ROWS-2:0];
      if (ctrl.mode) begin
         merged[mvt_pkg::NUM_ROWS-1] = '0;
      end else begin
         merged_sat = merged_sat | lane_clip[mvt_pkg::NUM_ROWS-1];
      end
      entry_in = {merged_sat, merged};
   end

   assign push = ctrl.valid;
   assign pop  = rsp_pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + LEVEL_W'(push) - LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign rsp_valid = (level_ff != '0);
   assign rsp_res   = fifo_ff[rd_ptr_ff][ENTRY_W-2:0];
   assign rsp_sat   = fifo_ff[rd_ptr_ff][ENTRY_W-1];

endmodule

// ===== hdl/matrix_vector_transform_unit.sv =====
// ============================================================================
// Matrix vector transform unit
// Multiplies one vector per transfer by a 4x4 matrix of signed Q4.12
// coefficients, four row lanes in parallel, with floor shift and saturation.
// ============================================================================
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_tvalid/req_tready   tdata x,y,z,w; tuser mode
//   rsp      out        rsp_tvalid/rsp_tready   tdata x,y,z,w; tuser saturated
//   csr      in         csr_valid/csr_ready     csr_index, csr_data (column)
//
// One vector is accepted per cycle while req_tready is high. Each lane runs
// three register stages (products, sum, shift and saturate); a result is
// written into the result queue together with its control from ctrl3_ff.
// A credit counter admits a request only while fewer than eight items are
// outstanding, so req_tready comes from a register, never from rsp_tready.
// Reset clears valids, queue and counter and loads the default matrix.
//
module matrix_vector_transform_unit #(
   parameter int VECTOR_WIDTH = mvt_pkg::VECTOR_WIDTH,
   parameter int COEF_WIDTH   = mvt_pkg::COEF_WIDTH,
   localparam int DATA_W      = ((mvt_pkg::NUM_COLS * VECTOR_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: vec_x, vec_y, vec_z, vec_w, zero fill.
   input  logic [DATA_W-1:0]                   req_tdata,
   // Fields from bit 0 up: mode.
   input  logic                                req_tuser,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: res_x, res_y, res_z, res_w, zero fill.
   output logic [DATA_W-1:0]                   rsp_tdata,
   // Fields from bit 0 up: saturated.
   output logic                                rsp_tuser,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mvt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mvt_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int NUM_ROWS  = mvt_pkg::NUM_ROWS;
   localparam int NUM_COLS  = mvt_pkg::NUM_COLS;
   localparam int STRIDE    = mvt_pkg::LANE_STRIDE;
   localparam int DEPTH     = mvt_pkg::RSP_FIFO_DEPTH;
   localparam int CREDIT_W  = $clog2(DEPTH + 1);
   localparam int PAYLOAD_W = NUM_COLS * VECTOR_WIDTH;

   // Coefficient store, indexed column then row; only the low COEF_WIDTH
   // bits of each 16-bit field of a column register are kept.
   logic [NUM_COLS-1:0][NUM_ROWS-1:0][COEF_WIDTH-1:0] coef_ff, coef_in;
   logic [NUM_COLS-1:0]                                col_wr;

   logic                                req_xfer;
   logic                                rsp_xfer;
   logic [CREDIT_W-1:0]                 credit_ff, credit_in;
   mvt_pkg::ctrl_type                   ctrl_in;
   mvt_pkg::ctrl_type                   ctrl1_ff, ctrl2_ff, ctrl3_ff;

   logic [NUM_COLS-1:0][VECTOR_WIDTH-1:0]          vec;
   logic [NUM_ROWS-1:0][VECTOR_WIDTH-1:0]          lane_res;
   logic [NUM_ROWS-1:0]                            lane_clip;
   logic [NUM_ROWS-1:0][VECTOR_WIDTH-1:0]          rsp_res;
   logic                                           rsp_sat;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      col_wr = '0;
      if (csr_valid) begin
         case (mvt_pkg::csr_index_type'(csr_index))
            mvt_pkg::CSR_MATRIX_COL0: col_wr[0] = 1'b1;
            mvt_pkg::CSR_MATRIX_COL1: col_wr[1] = 1'b1;
            mvt_pkg::CSR_MATRIX_COL2: col_wr[2] = 1'b1;
            mvt_pkg::CSR_MATRIX_COL3: col_wr[3] = 1'b1;
            default:                  col_wr    = '0;
         endcase
      end
   end

   always_comb begin
      coef_in = coef_ff;
      for (int c = 0; c < NUM_COLS; c++) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            if (col_wr[c]) begin
               coef_in[c][r] = csr_data[r*STRIDE +: COEF_WIDTH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
               coef_ff[c][r] <= mvt_pkg::MATRIX_RESET[c][r*STRIDE +: COEF_WIDTH];
            end
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   // ---------------------------------------------------------------------
   // Request side: credit counter and control pipeline
   // ---------------------------------------------------------------------
   assign req_tready = (credit_ff < CREDIT_W'(DEPTH));
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   always_comb begin
      credit_in     = credit_ff + CREDIT_W'(req_xfer) - CREDIT_W'(rsp_xfer);
      ctrl_in.valid = req_xfer;
      ctrl_in.mode  = req_tuser;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         ctrl1_ff  <= '0;
         ctrl2_ff  <= '0;
         ctrl3_ff  <= '0;
      end else begin
         credit_ff <= credit_in;
         ctrl1_ff  <= ctrl_in;
         ctrl2_ff  <= ctrl1_ff;
         ctrl3_ff  <= ctrl2_ff;
      end
   end

   // Unpack the vector; the w component is zeroed in three-component mode so
   // the fourth column drops out of every row sum.
   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         vec[c] = req_tdata[c*VECTOR_WIDTH +: VECTOR_WIDTH];
      end
      if (req_tuser) begin
         vec[NUM_COLS-1] = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Row lanes, one per result component
   // ---------------------------------------------------------------------
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
      logic [NUM_COLS-1:0][COEF_WIDTH-1:0] coef_row;

      for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
         assign coef_row[c] = coef_ff[c][r];
      end

      mvt_lane #(
         .VECTOR_WIDTH (VECTOR_WIDTH),
         .COEF_WIDTH   (COEF_WIDTH)
      ) u_lane (
         .clock    (clock),
         .coef_row (coef_row),
         .vec      (vec),
         .res      (lane_res[r]),
         .clip     (lane_clip[r])
      );
   end

   // ---------------------------------------------------------------------
   // Merge and result queue
   // ---------------------------------------------------------------------
   mvt_merge #(
      .VECTOR_WIDTH (VECTOR_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl3_ff),
      .lane_res  (lane_res),
      .lane_clip (lane_clip),
      .rsp_pop   (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_res   (rsp_res),
      .rsp_sat   (rsp_sat)
   );

   assign rsp_tdata = DATA_W'(PAYLOAD_W'(rsp_res));
   assign rsp_tuser = rsp_sat;

endmodule
